### rtl/i2p_pkg.sv
// ----------------------------------------------------------------------------
// i2p_pkg
// Shared types, token codes and helpers for the infix to postfix converter.
// ----------------------------------------------------------------------------
`default_nettype none

package i2p_pkg;

  // operator stack geometry
  localparam int STACK_DEPTH = 32;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

  localparam int CODE_W   = 3;
  localparam int TAG_W    = 16;
  localparam int STATUS_W = 2;

  // input token kinds
  localparam logic [CODE_W-1:0] CMD_OPERAND = 3'd0;
  localparam logic [CODE_W-1:0] CMD_PLUS    = 3'd1;
  localparam logic [CODE_W-1:0] CMD_MINUS   = 3'd2;
  localparam logic [CODE_W-1:0] CMD_MUL     = 3'd3;
  localparam logic [CODE_W-1:0] CMD_DIV     = 3'd4;
  localparam logic [CODE_W-1:0] CMD_LPAREN  = 3'd5;
  localparam logic [CODE_W-1:0] CMD_RPAREN  = 3'd6;
  localparam logic [CODE_W-1:0] CMD_END     = 3'd7;

  // emitted token kinds
  localparam logic [CODE_W-1:0] KIND_OPERAND = 3'd0;
  localparam logic [CODE_W-1:0] KIND_NONE    = 3'd5;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_PAREN = 2'd1;
  localparam logic [STATUS_W-1:0] ST_OVFL  = 2'd2;

  typedef struct packed {
    logic [CODE_W-1:0] cmd;
    logic [TAG_W-1:0]  operand_tag;
  } in_item_t;

  typedef struct packed {
    logic [CODE_W-1:0]   out_kind;
    logic [TAG_W-1:0]    out_tag;
    logic [STATUS_W-1:0] status;
    logic                last;
  } out_item_t;

  // one result word handed from the sequencer to the output register
  typedef struct packed {
    logic      valid;
    out_item_t item;
  } emit_t;

  // arithmetic operator code
  function automatic logic is_op(input logic [CODE_W-1:0] code);
    return (code == CMD_PLUS) || (code == CMD_MINUS) || (code == CMD_MUL) ||
           (code == CMD_DIV);
  endfunction

  // high precedence operator
  function automatic logic prec_hi(input logic [CODE_W-1:0] code);
    return (code == CMD_MUL) || (code == CMD_DIV);
  endfunction

  function automatic out_item_t mk_item(input logic [CODE_W-1:0]   kind,
                                        input logic [TAG_W-1:0]    tag,
                                        input logic [STATUS_W-1:0] status,
                                        input logic                last);
    out_item_t it;
    it.out_kind = kind;
    it.out_tag  = tag;
    it.status   = status;
    it.last     = last;
    return it;
  endfunction

endpackage

`default_nettype wire

### rtl/i2p_oreg.sv
// ----------------------------------------------------------------------------
// i2p_oreg
// Output register: holds one result word until the consumer takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module i2p_oreg (
  input  logic              clk,
  input  logic              rst_n,
  input  i2p_pkg::emit_t    emit,
  output logic              out_free,
  output logic              out_valid,
  input  logic              out_stall,
  output i2p_pkg::out_item_t out_data
);
  import i2p_pkg::*;

  logic      valid_r, valid_nxt;
  out_item_t data_r;

  // slot is free when empty or being drained this cycle
  assign out_free  = !valid_r || !out_stall;
  assign valid_nxt = emit.valid || (valid_r && out_stall);

  // valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (emit.valid) begin
      data_r <= emit.item;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

`default_nettype wire

### rtl/i2p_ctrl.sv
// ----------------------------------------------------------------------------
// i2p_ctrl
// Token sequencer with the operator stack memory: pops one stack entry per
// cycle while the output slot is free, through a registered read port, and decides push, emit or terminate.
// ----------------------------------------------------------------------------
`default_nettype none

module i2p_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  i2p_pkg::in_item_t in_data,
  input  logic              out_free,
  output i2p_pkg::emit_t    emit
);
  import i2p_pkg::*;

  typedef enum logic {S_IDLE, S_EVAL} state_t;

  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [CODE_W-1:0]   cmd_r, cmd_nxt;

  logic [CODE_W-1:0]   stack_mem [STACK_DEPTH];
  logic [CODE_W-1:0]   rd_data_r;
  logic                rd_en, wr_en;
  logic [ADDR_W-1:0]   rd_addr, wr_addr;

  logic                accept, empty, full, top_lp, do_pop;
  logic [CNT_W-1:0]    cnt_dec, cnt_dec2, cnt_inc;

  assign in_stall = (state_r != S_IDLE) || !out_free;
  assign accept   = in_valid && !in_stall;

  assign cnt_dec  = cnt_r - CNT_W'(1);
  assign cnt_dec2 = cnt_r - CNT_W'(2);
  assign cnt_inc  = cnt_r + CNT_W'(1);
  assign empty    = (cnt_r == '0);
  assign full     = (cnt_r == CNT_W'(STACK_DEPTH));
  assign top_lp   = (rd_data_r == CMD_LPAREN);
  assign wr_addr  = cnt_r[ADDR_W-1:0];

  // pop and emit the top entry for this token
  always_comb begin
    do_pop = 1'b0;
    if (!empty) begin
      if (is_op(cmd_r)) begin
        do_pop = is_op(rd_data_r) && (!prec_hi(cmd_r) || prec_hi(rd_data_r));
      end else if ((cmd_r == CMD_RPAREN) || (cmd_r == CMD_END)) begin
        do_pop = !top_lp;
      end
    end
  end

  // sequencer next state
  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    cmd_nxt    = cmd_r;
    rd_en      = 1'b0;
    rd_addr    = cnt_dec[ADDR_W-1:0];
    wr_en      = 1'b0;
    emit.valid = 1'b0;
    emit.item  = mk_item(KIND_NONE, '0, ST_OK, 1'b0);
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_data.cmd == CMD_OPERAND) begin
            emit.valid = 1'b1;
            emit.item  = mk_item(KIND_OPERAND, in_data.operand_tag, ST_OK, 1'b0);
          end else begin
            cmd_nxt   = in_data.cmd;
            state_nxt = S_EVAL;
            rd_en     = !empty;
          end
        end
      end
      S_EVAL: begin
        priority if (do_pop) begin
          if (out_free) begin
            emit.valid = 1'b1;
            emit.item  = mk_item(rd_data_r, '0, ST_OK, 1'b0);
            cnt_nxt    = cnt_dec;
            rd_en      = (cnt_dec != '0);
            rd_addr    = cnt_dec2[ADDR_W-1:0];
          end
        end else if (is_op(cmd_r) || (cmd_r == CMD_LPAREN)) begin
          if (full) begin
            if (out_free) begin
              emit.valid = 1'b1;
              emit.item  = mk_item(KIND_NONE, '0, ST_OVFL, 1'b1);
              cnt_nxt    = '0;
              state_nxt  = S_IDLE;
            end
          end else begin
            wr_en     = 1'b1;
            cnt_nxt   = cnt_inc;
            state_nxt = S_IDLE;
          end
        end else if (empty) begin
          // right paren with no match, or normal end
          if (out_free) begin
            emit.valid = 1'b1;
            emit.item  = mk_item(KIND_NONE, '0,
                                 (cmd_r == CMD_RPAREN) ? ST_PAREN : ST_OK, 1'b1);
            state_nxt  = S_IDLE;
          end
        end else if (cmd_r == CMD_RPAREN) begin
          // matching left paren is dropped
          cnt_nxt   = cnt_dec;
          state_nxt = S_IDLE;
        end else begin
          // leftover left paren at end
          if (out_free) begin
            emit.valid = 1'b1;
            emit.item  = mk_item(KIND_NONE, '0, ST_PAREN, 1'b1);
            cnt_nxt    = '0;
            state_nxt  = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state and stack count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      cmd_r   <= CMD_OPERAND;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      cmd_r   <= cmd_nxt;
    end
  end

  // operator stack memory, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      stack_mem[wr_addr] <= cmd_r;
    end
    if (rd_en) begin
      rd_data_r <= stack_mem[rd_addr];
    end
  end

  // a result is only produced into a free output slot
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    emit.valid |-> out_free)
    else $error("result produced while output slot busy");

  // a push grows the stack by exactly one
  a_push_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |=> (cnt_r == $past(cnt_inc)))
    else $error("stack count wrong after push");

  // a terminating result ends the token
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (emit.valid && emit.item.last) |=> (state_r == S_IDLE))
    else $error("sequencer busy after terminating result");

  // error status only on a terminating result
  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    (emit.valid && (emit.item.status != ST_OK)) |-> emit.item.last)
    else $error("error status on a non-terminating result");

endmodule

`default_nettype wire

### rtl/infix_to_postfix_converter_top.sv
// ----------------------------------------------------------------------------
// infix_to_postfix_converter_top
// Shunting-yard converter from classified infix tokens to postfix tokens.
// ----------------------------------------------------------------------------
// An operand word appears at the output in the cycle after acceptance, and
// operands are taken one per cycle while the output is not stalled. Operator,
// paren and end words stall input while the single stack read port pops
// entries one at a time while the output is free, then push or terminate.
// Reset clears the sequencer, stack count and output valid; the stack memory
// is not cleared, since entries above the count are never read.
`default_nettype none

module infix_to_postfix_converter_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  i2p_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output i2p_pkg::out_item_t out_data
);
  import i2p_pkg::*;

  emit_t emit;
  logic  out_free;

  // token sequencer and operator stack
  i2p_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_free (out_free),
    .emit     (emit)
  );

  // result output register
  i2p_oreg u_oreg (
    .clk       (clk),
    .rst_n     (rst_n),
    .emit      (emit),
    .out_free  (out_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

### dv/infix_to_postfix_converter_top_tb.sv
// ----------------------------------------------------------------------------
// infix_to_postfix_converter_top_tb
// Self-checking bench for the infix to postfix converter. Drives directed
// expressions (every operator, extreme tags, paren errors, stack overflow)
// and then random expressions, broken expressions and loose tokens. Both
// sides idle at random. A tracker with its own operator stack predicts every
// postfix word and checks the block's output in order.
// ----------------------------------------------------------------------------
`default_nettype none

module infix_to_postfix_converter_top_tb;

  import i2p_pkg::*;

  localparam int RAND_ITEMS  = 56;
  localparam int HOLD_CYCLES = 300;
  localparam int END_SETTLE  = STACK_DEPTH + 8;
  localparam int IDLE_LIMIT  = 2000;

  localparam logic [CODE_W-1:0] ARITH_OPS [4] = '{CMD_PLUS, CMD_MINUS, CMD_MUL, CMD_DIV};

  typedef enum int {PACE_FREE, PACE_COIN, PACE_EVERY3, PACE_HEAVY} pace_e;

  // expected postfix words and the operator stack behind them
  class postfix_tracker;
    logic [CODE_W-1:0] op_stk [STACK_DEPTH];
    int                op_cnt;
    out_item_t         due_q [$];
    int                errors;

    function new();
      op_cnt = 0;
      errors = 0;
    endfunction

    function void want(input logic [CODE_W-1:0] kind, input logic [TAG_W-1:0] tag,
                       input logic [STATUS_W-1:0] st, input logic last);
      out_item_t w;
      w.out_kind = kind;
      w.out_tag  = tag;
      w.status   = st;
      w.last     = last;
      due_q.push_back(w);
    endfunction

    function bit binds_tight(input logic [CODE_W-1:0] code);
      return (code == CMD_MUL) || (code == CMD_DIV);
    endfunction

    // a push onto a full stack drops the push and ends the expression
    function void push_op(input logic [CODE_W-1:0] code);
      if (op_cnt >= STACK_DEPTH) begin
        op_cnt = 0;
        want(KIND_NONE, '0, ST_OVFL, 1'b1);
      end else begin
        op_stk[op_cnt] = code;
        op_cnt++;
      end
    endfunction

    function void note_token(input in_item_t w);
      bit found_lp;
      found_lp = 1'b0;
      case (w.cmd)
        CMD_OPERAND: want(KIND_OPERAND, w.operand_tag, ST_OK, 1'b0);
        CMD_PLUS, CMD_MINUS, CMD_MUL, CMD_DIV: begin
          // pop operators of equal or higher precedence
          while (op_cnt > 0 && op_stk[op_cnt-1] != CMD_LPAREN &&
                 (!binds_tight(w.cmd) || binds_tight(op_stk[op_cnt-1]))) begin
            op_cnt--;
            want(op_stk[op_cnt], '0, ST_OK, 1'b0);
          end
          push_op(w.cmd);
        end
        CMD_LPAREN: push_op(CMD_LPAREN);
        CMD_RPAREN: begin
          // pop down to the matching left paren
          while (op_cnt > 0 && !found_lp) begin
            op_cnt--;
            if (op_stk[op_cnt] == CMD_LPAREN) found_lp = 1'b1;
            else want(op_stk[op_cnt], '0, ST_OK, 1'b0);
          end
          if (!found_lp) want(KIND_NONE, '0, ST_PAREN, 1'b1);
        end
        default: begin
          // end mark: flush, a leftover left paren is an error
          while (op_cnt > 0 && !found_lp) begin
            op_cnt--;
            if (op_stk[op_cnt] == CMD_LPAREN) found_lp = 1'b1;
            else want(op_stk[op_cnt], '0, ST_OK, 1'b0);
          end
          if (found_lp) begin
            op_cnt = 0;
            want(KIND_NONE, '0, ST_PAREN, 1'b1);
          end else begin
            want(KIND_NONE, '0, ST_OK, 1'b1);
          end
        end
      endcase
    endfunction

    function void field_check(input string name, input logic [TAG_W-1:0] exp_v,
                              input logic [TAG_W-1:0] got_v);
      if (got_v !== exp_v) begin
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_v, got_v);
        errors++;
      end
    endfunction

    function void check_word(input out_item_t got);
      out_item_t w;
      if (due_q.size() == 0) begin
        $display("%0t: unexpected word, expected none actual kind %0h tag %0h status %0h last %0b",
                 $time, got.out_kind, got.out_tag, got.status, got.last);
        errors++;
        return;
      end
      w = due_q.pop_front();
      field_check("out_kind", w.out_kind, got.out_kind);
      field_check("out_tag", w.out_tag, got.out_tag);
      field_check("status", w.status, got.status);
      field_check("last", w.last, got.last);
    endfunction

    function int outstanding();
      return due_q.size();
    endfunction
  endclass

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;

  postfix_tracker board;
  in_item_t       token_q [$];
  int             rand_start;
  logic           hold_go;
  int             idle_cycles;

  infix_to_postfix_converter_top u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic in_item_t tok(input logic [CODE_W-1:0] cmd, input logic [TAG_W-1:0] tag);
    in_item_t t;
    t.cmd         = cmd;
    t.operand_tag = tag;
    return t;
  endfunction

  // random expression, optionally with one token corrupted
  task automatic add_expression(input bit broken);
    in_item_t    seq [$];
    int unsigned nest;
    int unsigned terms;
    int unsigned term_goal;
    bit          done;
    nest      = 0;
    terms     = 0;
    term_goal = $urandom_range(1, 7);
    done      = 1'b0;
    while (!done) begin
      while (nest < 4 && $urandom_range(0, 3) == 0) begin
        seq.push_back(tok(CMD_LPAREN, TAG_W'($urandom)));
        nest++;
      end
      seq.push_back(tok(CMD_OPERAND, TAG_W'($urandom)));
      terms++;
      while (nest > 0 && $urandom_range(0, 2) == 0) begin
        seq.push_back(tok(CMD_RPAREN, TAG_W'($urandom)));
        nest--;
      end
      if (terms >= term_goal) done = 1'b1;
      else seq.push_back(tok(ARITH_OPS[$urandom_range(0, 3)], TAG_W'($urandom)));
    end
    repeat (nest) seq.push_back(tok(CMD_RPAREN, TAG_W'($urandom)));
    seq.push_back(tok(CMD_END, TAG_W'($urandom)));
    if (broken) seq[$urandom_range(0, seq.size() - 1)].cmd = CODE_W'($urandom_range(0, 7));
    foreach (seq[i]) token_q.push_back(seq[i]);
  endtask

  // offer one word and hold it until accepted
  task automatic push_token(input in_item_t w);
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (in_stall);
    board.note_token(w);
  endtask

  // receiver stall pattern, with one long hold-off once random traffic starts
  initial begin : out_pacer
    pace_e       mode;
    int unsigned left;
    bit          held;
    mode = PACE_FREE;
    left = 0;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_go && !held) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      if (left == 0) begin
        mode = pace_e'($urandom_range(0, 3));
        left = $urandom_range(16, 80);
      end
      left--;
      case (mode)
        PACE_FREE:   out_stall <= 1'b0;
        PACE_COIN:   out_stall <= ($urandom_range(0, 1) == 1);
        PACE_EVERY3: out_stall <= (left % 3 == 0);
        default:     out_stall <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // output check and watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) board.check_word(out_data);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no word moved for %0d cycles", $time, IDLE_LIMIT);
        $display("[infix_to_postfix_converter_top] ERROR");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin : main
    int unsigned burst;
    int unsigned gap;
    int unsigned pick;
    int unsigned depth;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    out_stall   = 1'b0;
    hold_go     = 1'b0;
    idle_cycles = 0;
    board       = new();

    // all four operators with extreme tags, normal end
    token_q.push_back(tok(CMD_OPERAND, 16'h0000));
    token_q.push_back(tok(CMD_PLUS, '0));
    token_q.push_back(tok(CMD_OPERAND, 16'hFFFF));
    token_q.push_back(tok(CMD_MUL, '0));
    token_q.push_back(tok(CMD_OPERAND, 16'h5A5A));
    token_q.push_back(tok(CMD_MINUS, '0));
    token_q.push_back(tok(CMD_OPERAND, 16'hA5A5));
    token_q.push_back(tok(CMD_DIV, '0));
    token_q.push_back(tok(CMD_OPERAND, 16'h0001));
    token_q.push_back(tok(CMD_END, '0));
    // parenthesized group
    token_q.push_back(tok(CMD_LPAREN, '0));
    token_q.push_back(tok(CMD_OPERAND, 16'h1234));
    token_q.push_back(tok(CMD_MINUS, '0));
    token_q.push_back(tok(CMD_OPERAND, 16'h8000));
    token_q.push_back(tok(CMD_RPAREN, '0));
    token_q.push_back(tok(CMD_DIV, '0));
    token_q.push_back(tok(CMD_OPERAND, 16'h7FFF));
    token_q.push_back(tok(CMD_END, '0));
    // unmatched right paren with an operator on the stack
    token_q.push_back(tok(CMD_OPERAND, 16'h00FF));
    token_q.push_back(tok(CMD_PLUS, '0));
    token_q.push_back(tok(CMD_OPERAND, 16'hFF00));
    token_q.push_back(tok(CMD_RPAREN, '0));
    // leftover left paren at end
    token_q.push_back(tok(CMD_LPAREN, '0));
    token_q.push_back(tok(CMD_OPERAND, 16'h0F0F));
    token_q.push_back(tok(CMD_MUL, '0));
    token_q.push_back(tok(CMD_OPERAND, 16'hF0F0));
    token_q.push_back(tok(CMD_END, '0));
    // operator pushed onto a full stack, then end on an empty stack
    repeat (STACK_DEPTH) token_q.push_back(tok(CMD_LPAREN, '0));
    token_q.push_back(tok(CMD_OPERAND, 16'hBEEF));
    token_q.push_back(tok(CMD_MUL, '0));
    token_q.push_back(tok(CMD_END, '0));

    // random traffic: mostly well-formed, some broken, some loose tokens
    rand_start = token_q.size();
    while (token_q.size() < rand_start + RAND_ITEMS) begin
      pick = $urandom_range(0, 24);
      if (pick == 0) begin
        depth = $urandom_range(STACK_DEPTH - 3, STACK_DEPTH + 2);
        repeat (depth) token_q.push_back(tok(CMD_LPAREN, TAG_W'($urandom)));
        token_q.push_back(tok(CMD_OPERAND, TAG_W'($urandom)));
        token_q.push_back(tok(ARITH_OPS[$urandom_range(0, 3)], TAG_W'($urandom)));
        token_q.push_back(tok(CMD_OPERAND, TAG_W'($urandom)));
        token_q.push_back(tok(CMD_END, TAG_W'($urandom)));
      end else if (pick <= 3) begin
        repeat ($urandom_range(1, 5)) begin
          token_q.push_back(tok(CODE_W'($urandom_range(0, 7)), TAG_W'($urandom)));
        end
      end else begin
        add_expression(pick <= 6);
      end
    end

    // reset
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // sender bursts and gaps
    burst = 0;
    foreach (token_q[i]) begin
      if (i == rand_start) hold_go <= 1'b1;
      if (burst == 0) begin
        burst = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 10);
        gap   = $urandom_range(0, 5);
        if (gap != 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      burst--;
      push_token(token_q[i]);
    end
    in_valid <= 1'b0;

    // drain
    while (board.outstanding() != 0) @(posedge clk);
    repeat (END_SETTLE) @(posedge clk);
    if (board.errors == 0) begin
      $display("[infix_to_postfix_converter_top] OK");
    end else begin
      $display("[infix_to_postfix_converter_top] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

### filelist.f
rtl/i2p_pkg.sv
rtl/i2p_oreg.sv
rtl/i2p_ctrl.sv
rtl/infix_to_postfix_converter_top.sv
dv/infix_to_postfix_converter_top_tb.sv
